@@ rtl/core/tos_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tos_pkg
// Types, codes and helpers shared by the typed operand stack modules.
// ----------------------------------------------------------------------------
package tos_pkg;

  localparam int CNT_W  = 9;
  localparam int WORD_W = 32;

  // operation kinds
  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_POP  = 2'd1;
  localparam logic [1:0] KIND_PEEK = 2'd2;

  // value type codes
  localparam logic [2:0] VT_INT    = 3'd0;
  localparam logic [2:0] VT_FLOAT  = 3'd1;
  localparam logic [2:0] VT_LONG   = 3'd2;
  localparam logic [2:0] VT_DOUBLE = 3'd3;
  localparam logic [2:0] VT_BOOL   = 3'd4;
  localparam logic [2:0] VT_REF    = 3'd5;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_OVF   = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // configuration register index (paddr[2])
  localparam logic REG_SLOT_LIMIT = 1'b0;
  localparam logic REG_REF_IS_64  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WR_HI,
    S_RD_TOP,
    S_RD_LO,
    S_DONE
  } tos_state_t;

  typedef struct packed {
    logic load;     // latch the input word, read the top entry's type
    logic eval;     // decide, write low slot on push, read top slot on pop/peek
    logic wr_hi;    // write high slot of a two-slot push
    logic cap_top;  // capture top slot, read the one below
    logic cap_lo;   // capture low slot of a two-slot entry
    logic commit;   // update counts and load the result register
  } tos_cmd_t;

  typedef struct packed {
    logic push_two_go;
    logic rd_go;
    logic rd_two;
    logic out_busy;
  } tos_sts_t;

  function automatic logic pair_type(input logic [2:0] t, input logic ref64);
    pair_type = (t == VT_LONG) || (t == VT_DOUBLE) || ((t == VT_REF) && ref64);
  endfunction

endpackage

@@ rtl/core/typed_operand_stack_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_operand_stack_top
// Typed operand stack of 32-bit slots with an APB-style configuration port.
// Steps: latch the input word and read the top entry's type, decide; then a
//   two-slot push writes its high slot, a pop/peek captures the top slot and
//   for a two-slot entry the low slot; commit waits while the output stalls.
// A new word is taken only after the last one is committed; the single
//   slot-memory port serves the low and high slot of a two-slot entry in turn.
// Reset: counts cleared, slot_limit 256, ref_is_64 0; memories keep contents.
// ----------------------------------------------------------------------------
module typed_operand_stack_top
  import tos_pkg::*;
#(
  parameter int SLOT_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [63:0] value,
  input  logic [2:0]  value_type,
  input  logic [3:0]  real_type,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [63:0] entry_value,
  output logic [2:0]  entry_type,
  output logic [3:0]  top_real_type,
  output logic [8:0]  slots_used
);

  logic [CNT_W-1:0] slot_limit;
  logic             ref_is_64;
  logic             reg_wr;
  tos_cmd_t         cmd;
  tos_sts_t         sts;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_limit <= CNT_W'(256);
      ref_is_64  <= 1'b0;
    end else if (reg_wr) begin
      case (paddr[2])
        REG_SLOT_LIMIT: slot_limit <= pwdata[CNT_W-1:0];
        REG_REF_IS_64:  ref_is_64  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SLOT_LIMIT: prdata = 32'(slot_limit);
      REG_REF_IS_64:  prdata = 32'(ref_is_64);
      default:        prdata = '0;
    endcase
  end

  tos_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tos_dpath #(
    .SLOT_DEPTH (SLOT_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .slot_limit    (slot_limit),
    .ref_is_64     (ref_is_64),
    .kind          (kind),
    .value         (value),
    .value_type    (value_type),
    .real_type     (real_type),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .entry_value   (entry_value),
    .entry_type    (entry_type),
    .top_real_type (top_real_type),
    .slots_used    (slots_used)
  );

endmodule

@@ rtl/core/tos_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tos_ctrl
// Sequencer for one stack operation: accept, decide, slot accesses, commit.
// ----------------------------------------------------------------------------
module tos_ctrl
  import tos_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  tos_sts_t sts,
  output tos_cmd_t cmd
);

  tos_state_t state;
  tos_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.eval = 1'b1;
        if (sts.push_two_go) begin
          state_next = S_WR_HI;
        end else if (sts.rd_go) begin
          state_next = S_RD_TOP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WR_HI: begin
        cmd.wr_hi  = 1'b1;
        state_next = S_DONE;
      end
      S_RD_TOP: begin
        cmd.cap_top = 1'b1;
        state_next  = sts.rd_two ? S_RD_LO : S_DONE;
      end
      S_RD_LO: begin
        cmd.cap_lo = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free or draining
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/tos_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tos_dpath
// Slot memory, entry type memory, counters and the result register.
// ----------------------------------------------------------------------------
module tos_dpath
  import tos_pkg::*;
#(
  parameter int SLOT_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  tos_cmd_t         cmd,
  output tos_sts_t         sts,
  input  logic [CNT_W-1:0] slot_limit,
  input  logic             ref_is_64,
  input  logic [1:0]       kind,
  input  logic [63:0]      value,
  input  logic [2:0]       value_type,
  input  logic [3:0]       real_type,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       status,
  output logic [63:0]      entry_value,
  output logic [2:0]       entry_type,
  output logic [3:0]       top_real_type,
  output logic [CNT_W-1:0] slots_used
);

  localparam int AW   = $clog2(SLOT_DEPTH);
  localparam int EC_W = $clog2(SLOT_DEPTH + 1);
  localparam int XW   = ((AW + 1 > CNT_W) ? AW + 1 : CNT_W) + 1;

  // latched input word
  logic [1:0]  kind_q;
  logic [63:0] value_q;
  logic [2:0]  vtype_q;
  logic [3:0]  rtype_q;

  logic [CNT_W-1:0] slot_count;
  logic [EC_W-1:0]  entry_count;

  logic             need2_q;
  logic             push_ok_q;
  logic             pop_q;
  logic             top_ok;
  logic             sec_ok;
  logic [1:0]       status_q;
  logic [2:0]       tt_q;
  logic [3:0]       trt_q;
  logic [WORD_W-1:0] val_hi;
  logic [WORD_W-1:0] val_lo;

  logic [WORD_W-1:0] slot_mem [SLOT_DEPTH];
  logic [WORD_W-1:0] slot_rdata;
  logic [6:0]        ent_mem [SLOT_DEPTH];
  logic [6:0]        ent_rdata;

  logic              is_push;
  logic              is_rd;
  logic              type_ok;
  logic              push_two;
  logic              rd_two;
  logic              overflow;
  logic              empty;
  logic              push_ok;
  logic              rd_go;
  logic [XW-1:0]     sc_x;
  logic [XW-1:0]     ec_x;
  logic [XW-1:0]     lim_x;
  logic [XW-1:0]     need_x;
  logic [XW-1:0]     sc_p1;
  logic [XW-1:0]     sc_m1;
  logic [XW-1:0]     sc_m2;
  logic [XW-1:0]     ec_m1;
  logic              slot_we;
  logic [AW-1:0]     slot_addr;
  logic [WORD_W-1:0] slot_wdata;
  logic [WORD_W-1:0] lo_word;
  logic [CNT_W-1:0]  slot_count_next;
  logic [EC_W-1:0]   entry_count_next;

  always_comb begin
    is_push  = (kind_q == KIND_PUSH);
    is_rd    = (kind_q == KIND_POP) || (kind_q == KIND_PEEK);
    type_ok  = (vtype_q <= VT_REF);
    push_two = pair_type(vtype_q, ref_is_64);
    rd_two   = pair_type(ent_rdata[6:4], ref_is_64);

    sc_x   = XW'(slot_count);
    ec_x   = XW'(entry_count);
    lim_x  = (XW'(slot_limit) < XW'(SLOT_DEPTH)) ? XW'(slot_limit) : XW'(SLOT_DEPTH);
    need_x = push_two ? XW'(2) : XW'(1);
    sc_p1  = sc_x + XW'(1);
    sc_m1  = sc_x - XW'(1);
    sc_m2  = sc_x - XW'(2);
    ec_m1  = ec_x - XW'(1);

    overflow = ((sc_x + need_x) > lim_x) || (ec_x >= XW'(SLOT_DEPTH));
    push_ok  = is_push && type_ok && !overflow;
    empty    = (entry_count == '0);
    rd_go    = is_rd && !empty;

    sts.push_two_go = push_ok && push_two;
    sts.rd_go       = rd_go;
    sts.rd_two      = need2_q;
    sts.out_busy    = out_valid && out_stall;

    // bool is stored as 0 or 1
    lo_word = (vtype_q == VT_BOOL) ? WORD_W'(|value_q[7:0]) : value_q[WORD_W-1:0];

    slot_we    = 1'b0;
    slot_addr  = sc_m2[AW-1:0];
    slot_wdata = lo_word;
    if (cmd.eval && push_ok) begin
      slot_we   = 1'b1;
      slot_addr = sc_x[AW-1:0];
    end else if (cmd.wr_hi) begin
      slot_we    = 1'b1;
      slot_addr  = sc_p1[AW-1:0];
      slot_wdata = value_q[63:32];
    end else if (cmd.eval) begin
      slot_addr = sc_m1[AW-1:0];
    end

    slot_count_next  = slot_count;
    entry_count_next = entry_count;
    if (push_ok_q) begin
      slot_count_next  = slot_count + (need2_q ? CNT_W'(2) : CNT_W'(1));
      entry_count_next = entry_count + EC_W'(1);
    end else if (pop_q) begin
      // missing slots read as zero and the count stops at zero
      if (need2_q) begin
        slot_count_next = (slot_count > CNT_W'(1)) ? slot_count - CNT_W'(2) : '0;
      end else begin
        slot_count_next = (slot_count != '0) ? slot_count - CNT_W'(1) : '0;
      end
      entry_count_next = entry_count - EC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_addr] <= slot_wdata;
    end
    slot_rdata <= slot_mem[slot_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && push_ok) begin
      ent_mem[entry_count[AW-1:0]] <= {vtype_q, rtype_q};
    end
    if (cmd.load) begin
      ent_rdata <= ent_mem[ec_m1[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= kind;
      value_q <= value;
      vtype_q <= value_type;
      rtype_q <= real_type;
    end
    if (cmd.eval) begin
      if (is_push && type_ok && overflow) begin
        status_q <= STAT_OVF;
      end else if (is_rd && empty) begin
        status_q <= STAT_EMPTY;
      end else begin
        status_q <= STAT_OK;
      end
      tt_q    <= rd_go ? ent_rdata[6:4] : 3'd0;
      trt_q   <= rd_go ? ent_rdata[3:0] : 4'd0;
      need2_q <= is_push ? push_two : rd_two;
      top_ok  <= (slot_count != '0);
      sec_ok  <= (slot_count > CNT_W'(1));
      val_hi  <= '0;
      val_lo  <= '0;
    end
    if (cmd.cap_top) begin
      if (need2_q) begin
        val_hi <= top_ok ? slot_rdata : '0;
      end else begin
        val_lo <= top_ok ? slot_rdata : '0;
      end
    end
    if (cmd.cap_lo) begin
      val_lo <= sec_ok ? slot_rdata : '0;
    end
    if (cmd.commit) begin
      status        <= status_q;
      entry_value   <= {val_hi, val_lo};
      entry_type    <= tt_q;
      top_real_type <= trt_q;
      slots_used    <= slot_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push_ok_q <= 1'b0;
      pop_q     <= 1'b0;
    end else if (cmd.eval) begin
      push_ok_q <= push_ok;
      pop_q     <= rd_go && (kind_q == KIND_POP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count  <= '0;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.commit) begin
        slot_count  <= slot_count_next;
        entry_count <= entry_count_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sim/typed_operand_stack_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_operand_stack_top_test
// Self-checking bench for the typed operand stack. A local shadow of the slot,
// type and real-type stores predicts every result word; words are checked in
// order against the outputs while both handshakes idle at random.
// ----------------------------------------------------------------------------
module typed_operand_stack_top_test
  import tos_pkg::*;
();

  localparam int STACK_DEPTH = 256;
  localparam int STUCK_LIMIT = 4000;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [2:0] VT_BAD_A  = 3'd6;
  localparam logic [2:0] VT_BAD_B  = 3'd7;

  typedef struct packed {
    logic [1:0]  st;
    logic [63:0] val;
    logic [2:0]  ty;
    logic [3:0]  rty;
    logic [8:0]  used;
  } stack_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  kind;
  logic [63:0] value;
  logic [2:0]  value_type;
  logic [3:0]  real_type;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [63:0] entry_value;
  logic [2:0]  entry_type;
  logic [3:0]  top_real_type;
  logic [8:0]  slots_used;

  // shadow of the stack and its registers
  logic [31:0] slot_mem  [STACK_DEPTH];
  logic [2:0]  type_mem  [STACK_DEPTH];
  logic [3:0]  rtype_mem [STACK_DEPTH];
  int          used_slots   = 0;
  int          live_entries = 0;
  int          cfg_limit    = STACK_DEPTH;
  bit          ref_wide     = 1'b0;

  stack_result_t pending_results[$];
  int            mismatches   = 0;
  int            stuck_cycles = 0;
  bit            no_idle      = 1'b0;

  typed_operand_stack_top #(.SLOT_DEPTH(STACK_DEPTH)) u_dut (.*);

  always #2 clk = ~clk;

  function automatic bit takes_two(input logic [2:0] vt);
    return (vt == VT_LONG) || (vt == VT_DOUBLE) || ((vt == VT_REF) && ref_wide);
  endfunction

  // pos counts down from the top slot; slots under the floor read as zero
  function automatic logic [31:0] slot_below(input int pos);
    if (pos >= used_slots) return 32'd0;
    return slot_mem[used_slots - 1 - pos];
  endfunction

  function automatic stack_result_t predict_result(input logic [1:0] op,
                                                   input logic [63:0] bits,
                                                   input logic [2:0] vt,
                                                   input logic [3:0] rt);
    stack_result_t r;
    int need;
    int lim;
    int top;
    logic [31:0] lo;
    r = '0;
    if (op == KIND_PUSH) begin
      if (vt <= VT_REF) begin
        need = takes_two(vt) ? 2 : 1;
        lim = (cfg_limit < STACK_DEPTH) ? cfg_limit : STACK_DEPTH;
        if (used_slots + need > lim || live_entries >= STACK_DEPTH) begin
          r.st = STAT_OVF;
        end else begin
          lo = bits[31:0];
          if (vt == VT_BOOL) lo = (bits[7:0] != 8'd0) ? 32'd1 : 32'd0;
          slot_mem[used_slots] = lo;
          if (need == 2) slot_mem[used_slots + 1] = bits[63:32];
          used_slots += need;
          type_mem[live_entries] = vt;
          rtype_mem[live_entries] = rt;
          live_entries++;
        end
      end
    end else if (op == KIND_POP || op == KIND_PEEK) begin
      if (live_entries == 0) begin
        r.st = STAT_EMPTY;
      end else begin
        top = live_entries - 1;
        r.ty = type_mem[top];
        r.rty = rtype_mem[top];
        need = takes_two(r.ty) ? 2 : 1;
        if (need == 2) r.val = {slot_below(0), slot_below(1)};
        else r.val = {32'd0, slot_below(0)};
        if (op == KIND_POP) begin
          used_slots = (used_slots >= need) ? used_slots - need : 0;
          live_entries = top;
        end
      end
    end
    r.used = 9'(used_slots);
    return r;
  endfunction

  function automatic logic [63:0] random_payload();
    case ($urandom_range(9))
      0: return 64'd0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  task automatic send_word(input logic [1:0] op, input logic [63:0] bits,
                           input logic [2:0] vt, input logic [3:0] rt);
    if (!no_idle)
      while ($urandom_range(99) < 11) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid   <= 1'b1;
    kind       <= op;
    value      <= bits;
    value_type <= vt;
    real_type  <= rt;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_result(op, bits, vt, rt));
  endtask

  // hold off the sender until every word has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(input logic idx, input logic [31:0] data);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_SLOT_LIMIT) cfg_limit = int'(data[8:0]);
    else ref_wide = data[0];
  endtask

  task automatic test_empty_reads();
    send_word(KIND_POP, random_payload(), VT_INT, 4'hF);
    send_word(KIND_PEEK, random_payload(), VT_REF, 4'h0);
  endtask

  task automatic test_each_type();
    logic [2:0] all_types [6];
    all_types = '{VT_INT, VT_FLOAT, VT_LONG, VT_DOUBLE, VT_BOOL, VT_REF};
    foreach (all_types[i])
      send_word(KIND_PUSH, '1, all_types[i], (i % 2) ? 4'h0 : 4'hF);
    send_word(KIND_PEEK, 64'd0, VT_INT, 4'h0);
    repeat (6) send_word(KIND_POP, 64'd0, VT_INT, 4'h0);
    // bool keeps only whether the low byte is nonzero
    send_word(KIND_PUSH, 64'hFFFF_FFFF_FFFF_FF00, VT_BOOL, 4'h9);
    send_word(KIND_POP, 64'd0, VT_INT, 4'h0);
    send_word(KIND_PUSH, 64'd0, VT_LONG, 4'h0);
    send_word(KIND_POP, '1, VT_BAD_B, 4'hF);
    send_word(KIND_PUSH, '1, VT_BAD_A, 4'h5);
    send_word(KIND_PUSH, '1, VT_BAD_B, 4'hA);
    send_word(KIND_NONE, '1, VT_BAD_B, 4'hF);
  endtask

  task automatic test_refused_pushes();
    set_reg(REG_SLOT_LIMIT, 32'd0);
    send_word(KIND_PUSH, 64'h1234_5678_9ABC_DEF0, VT_INT, 4'h3);
    send_word(KIND_POP, 64'd0, VT_INT, 4'h0);
    set_reg(REG_SLOT_LIMIT, 32'd1);
    send_word(KIND_PUSH, 64'h0000_0000_CAFE_F00D, VT_INT, 4'h1);
    send_word(KIND_PUSH, 64'h0000_0000_3F80_0000, VT_FLOAT, 4'h2);
    send_word(KIND_POP, 64'd0, VT_INT, 4'h0);
    send_word(KIND_PUSH, '1, VT_LONG, 4'h4);
    set_reg(REG_SLOT_LIMIT, 32'd2);
    send_word(KIND_PUSH, 64'h4009_21FB_5444_2D18, VT_DOUBLE, 4'h6);
    send_word(KIND_POP, 64'd0, VT_INT, 4'h0);
    set_reg(REG_SLOT_LIMIT, 32'd256);
  endtask

  // width of a reference follows the register at each access, not at push
  task automatic test_reference_width();
    set_reg(REG_REF_IS_64, 32'd0);
    send_word(KIND_PUSH, 64'hAAAA_AAAA_5555_5555, VT_REF, 4'h7);
    set_reg(REG_REF_IS_64, 32'd1);
    send_word(KIND_PEEK, 64'd0, VT_INT, 4'h0);
    send_word(KIND_POP, 64'd0, VT_INT, 4'h0);
    send_word(KIND_PUSH, 64'h8765_4321_0FED_CBA9, VT_REF, 4'hC);
    set_reg(REG_REF_IS_64, 32'd0);
    send_word(KIND_POP, 64'd0, VT_INT, 4'h0);
    send_word(KIND_POP, 64'd0, VT_INT, 4'h0);
  endtask

  // shrink slots below entries so the entry ceiling is hit before the slot limit
  task automatic test_entry_ceiling();
    set_reg(REG_SLOT_LIMIT, 32'd256);
    set_reg(REG_REF_IS_64, 32'd0);
    repeat (128) send_word(KIND_PUSH, random_payload(), VT_REF, 4'($urandom_range(15)));
    set_reg(REG_REF_IS_64, 32'd1);
    repeat (64) send_word(KIND_POP, random_payload(), VT_INT, 4'h0);
    repeat (192) send_word(KIND_PUSH, random_payload(), VT_INT, 4'($urandom_range(15)));
    send_word(KIND_PUSH, random_payload(), VT_INT, 4'h8);
    // drain past the slot floor: missing slots read as zero
    repeat (256) send_word(KIND_POP, random_payload(), VT_INT, 4'h0);
    send_word(KIND_PEEK, random_payload(), VT_INT, 4'h0);
  endtask

  task automatic run_phase(input int lim, input bit wide, input int count,
                           input int push_pct, input bit calm);
    int r;
    logic [1:0] op;
    set_reg(REG_SLOT_LIMIT, 32'(lim));
    set_reg(REG_REF_IS_64, 32'(wide));
    no_idle = calm;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 3) begin
        send_word(KIND_NONE, random_payload(), 3'($urandom), 4'($urandom));
      end else if (r < 5) begin
        send_word(KIND_PUSH, random_payload(), $urandom_range(1) ? VT_BAD_A : VT_BAD_B,
                  4'($urandom));
      end else if (r < 5 + push_pct) begin
        send_word(KIND_PUSH, random_payload(), 3'($urandom_range(VT_REF)), 4'($urandom));
      end else begin
        op = ($urandom_range(3) == 0) ? KIND_PEEK : KIND_POP;
        send_word(op, random_payload(), 3'($urandom), 4'($urandom));
      end
      if ($urandom_range(149) == 0) settle();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_mix();
    run_phase(256, 1'b0, 150, 60, 1'b0);
    run_phase(256, 1'b1, 150, 70, 1'b0);
    run_phase(256, 1'b1, 120, 35, 1'b1);
    run_phase(0,   1'b0, 40,  60, 1'b0);
    run_phase(1,   1'b1, 60,  55, 1'b0);
    run_phase(2,   1'b0, 60,  55, 1'b0);
    run_phase(5,   1'b1, 90,  55, 1'b0);
    run_phase(256, 1'b0, 150, 85, 1'b0);
    run_phase(256, 1'b1, 100, 30, 1'b0);
  endtask

  always @(posedge clk) begin : check_results
    stack_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected word", 64'd0, entry_value);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st) note_mismatch("status", 64'(want.st), 64'(status));
        if (entry_value !== want.val) note_mismatch("entry_value", want.val, entry_value);
        if (entry_type !== want.ty)
          note_mismatch("entry_type", 64'(want.ty), 64'(entry_type));
        if (top_real_type !== want.rty)
          note_mismatch("top_real_type", 64'(want.rty), 64'(top_real_type));
        if (slots_used !== want.used)
          note_mismatch("slots_used", 64'(want.used), 64'(slots_used));
      end
    end
    out_stall <= !no_idle && ($urandom_range(99) < 11);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("typed_operand_stack_top_test: done, errors");
      $finish;
    end
  end

  initial begin
    rst        <= 1'b1;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_valid   <= 1'b0;
    kind       <= KIND_PUSH;
    value      <= '0;
    value_type <= VT_INT;
    real_type  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_reads();
    test_each_type();
    test_refused_pushes();
    test_reference_width();
    test_entry_ceiling();
    test_random_mix();
    settle();
    if (mismatches == 0 && pending_results.size() == 0)
      $display("typed_operand_stack_top_test: done, clean");
    else
      $display("typed_operand_stack_top_test: done, errors");
    $finish;
  end

endmodule
